[sv/lcdemu_pkg.sv]
// Shared types and constants for the character LCD bus emulator.
// No dependencies; imported by every module of the block.
package lcdemu_pkg;

	// Input transaction payload
	typedef struct packed {
		logic       opcode;
		logic [7:0] bus_byte;
		logic [1:0] read_row;
		logic [5:0] read_col;
	} in_item_t;

	// Result transaction payload
	typedef struct packed {
		logic [7:0] read_char;
		logic       backlight_on;
		logic [5:0] column_count;
		logic [6:0] cursor_address;
	} result_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec;
		logic clr_step;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_req;
		logic clr_last;
	} dp_status_t;

	// Opcodes
	localparam logic OP_BUS  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Expander byte bit positions
	localparam int BUS_BL = 3;
	localparam int BUS_EN = 2;
	localparam int BUS_RW = 1;
	localparam int BUS_RS = 0;

	// Command bytes
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_HOME_ALT = 8'h03;

	// Display memory layout
	localparam logic [6:0] ADDR_WRAP   = 7'h68;
	localparam logic [6:0] LINE1_END   = 7'h28;
	localparam logic [6:0] LINE2_START = 7'h40;
	localparam logic [5:0] FOLD_COL    = 6'd20;
	localparam logic [2:0] FOLD_ROWS   = 3'd4;

	localparam logic [8:0] ACC_EMPTY   = 9'h001;
	localparam logic [5:0] VIS_RESET   = 6'd20;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;

	// Configuration registers
	localparam logic       REG_DISPLAY_ROWS = 1'b0;
	localparam logic       REG_MAX_COLUMNS  = 1'b1;
	localparam logic [2:0] ROWS_RESET       = 3'd4;
	localparam logic [5:0] MAXCOL_RESET     = 6'd40;

endpackage

[sv/lcdemu_ctrl.sv]
// Controller state machine for the LCD bus emulator.
// Depends on lcdemu_pkg; drives commands to lcdemu_datapath.
module lcdemu_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  lcdemu_pkg::dp_status_t  status,
	output lcdemu_pkg::ctrl_cmd_t   cmd
);
	import lcdemu_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  state_d = status.clear_req ? ST_CLEAR : ST_DONE;
			ST_CLEAR: if (status.clr_last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.load_item = in_valid;
			ST_EXEC:  cmd.exec = 1'b1;
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_DONE:  cmd.load_out = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[sv/lcdemu_datapath.sv]
// Datapath of the LCD bus emulator: nibble pairing, address handling,
// text store memory and result register. Depends on lcdemu_pkg.
module lcdemu_datapath #(
	parameter int TEXT_ROWS = 4,
	parameter int TEXT_COLS = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdemu_pkg::ctrl_cmd_t  cmd,
	output lcdemu_pkg::dp_status_t status,
	input  lcdemu_pkg::in_item_t   in_data,
	output lcdemu_pkg::result_t    out_data,
	input  logic [2:0]             display_rows,
	input  logic [5:0]             max_columns
);
	import lcdemu_pkg::*;

	localparam int DEPTH = TEXT_ROWS * TEXT_COLS;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [5:0]       COLS_V = 6'(TEXT_COLS);
	localparam logic [2:0]       ROWS_V = 3'(TEXT_ROWS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	in_item_t   item_q;
	result_t    out_q;
	logic       sel_q;
	logic [8:0] acc_q;
	logic [6:0] addr_q;
	logic       disp_on_q;
	logic [5:0] vis_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic [DEPTH-1:0] valid_q;
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;
	logic       rd_hit_q;

	logic       is_bus, rs, done_byte, data_wr, cmd_clear, rd_en, rd_in, hit, fold;
	logic [8:0] acc_base, acc_new;
	logic [7:0] byte_v;
	logic [6:0] wa;
	logic [5:0] x0, x, x_inc, n_cols;
	logic [1:0] y0, y;
	logic [IDX_W-1:0] widx, ridx, mem_waddr;
	logic [7:0] mem_wdata;
	logic       mem_we;

	// Bus byte decode and nibble pairing
	assign is_bus = cmd.exec && (item_q.opcode == OP_BUS)
		&& item_q.bus_byte[BUS_EN] && !item_q.bus_byte[BUS_RW];
	assign rs        = item_q.bus_byte[BUS_RS];
	assign acc_base  = (sel_q != rs) ? ACC_EMPTY : acc_q;
	assign acc_new   = {acc_base[4:0], item_q.bus_byte[7:4]};
	assign done_byte = acc_new[8];
	assign byte_v    = acc_new[7:0];

	// Address wrap between lines and past the top, then fold onto a 4-row layout when four rows are configured
	always_comb begin
		if (addr_q >= ADDR_WRAP)
			wa = '0;
		else if (addr_q >= LINE1_END && addr_q < LINE2_START)
			wa = LINE2_START;
		else
			wa = addr_q;
	end

	assign x0   = wa[5:0];
	assign y0   = {1'b0, wa[6]};
	assign fold = (display_rows == FOLD_ROWS) && (x0 >= FOLD_COL);
	assign x    = fold ? (x0 - FOLD_COL) : x0;
	assign y    = fold ? (y0 + 2'd2) : y0;
	assign hit  = (x < COLS_V) && ({1'b0, y} < ROWS_V);
	assign widx = IDX_W'(y) * IDX_W'(TEXT_COLS) + IDX_W'(x);
	assign x_inc  = x + 6'd1;
	assign n_cols = (x_inc > max_columns) ? max_columns : x_inc;

	assign data_wr   = is_bus && done_byte && rs && hit;
	assign cmd_clear = is_bus && done_byte && !rs && (byte_v == CMD_CLEAR);

	// Read request
	assign rd_en = cmd.exec && (item_q.opcode == OP_READ);
	assign rd_in = (item_q.read_col < COLS_V) && ({1'b0, item_q.read_row} < ROWS_V);
	assign ridx  = IDX_W'(item_q.read_row) * IDX_W'(TEXT_COLS) + IDX_W'(item_q.read_col);

	// Memory write port: data byte or clear sweep
	assign mem_we    = data_wr || cmd.clr_step;
	assign mem_waddr = cmd.clr_step ? clr_idx_q : widx;
	assign mem_wdata = cmd.clr_step ? CHAR_SPACE : byte_v;

	assign status.clear_req = cmd_clear;
	assign status.clr_last  = (clr_idx_q == LAST_IDX);
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en) begin
			rd_data_q <= mem[ridx];
			rd_hit_q  <= rd_in && valid_q[ridx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_data;
		if (cmd.load_out) begin
			out_q.read_char      <= (item_q.opcode == OP_READ && rd_hit_q) ? rd_data_q : 8'h00;
			out_q.backlight_on   <= disp_on_q;
			out_q.column_count   <= vis_q;
			out_q.cursor_address <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			acc_q     <= ACC_EMPTY;
			addr_q    <= '0;
			disp_on_q <= 1'b0;
			vis_q     <= VIS_RESET;
			clr_idx_q <= '0;
			valid_q   <= '0;
		end else begin
			if (mem_we)
				valid_q[mem_waddr] <= 1'b1;
			if (cmd.clr_step)
				clr_idx_q <= status.clr_last ? '0 : clr_idx_q + 1'b1;
			if (is_bus) begin
				disp_on_q <= item_q.bus_byte[BUS_BL];
				sel_q     <= rs;
				acc_q     <= done_byte ? ACC_EMPTY : acc_new;
				if (done_byte) begin
					if (rs) begin
						addr_q <= wa + 7'd1;
						if (x >= vis_q)
							vis_q <= n_cols;
					end else if (byte_v[7]) begin
						addr_q <= byte_v[6:0];
					end else if (byte_v == CMD_HOME || byte_v == CMD_HOME_ALT
						|| byte_v == CMD_CLEAR) begin
						addr_q <= '0;
					end
				end
			end
		end
	end

endmodule

[sv/char_lcd_4bit_bus_emulator_top.sv]
// Character LCD 4-bit bus emulator: top level with APB configuration registers.
// Timing: an accepted input transaction passes through the execute and deliver states
//   of the controller before its result is registered; a clear command adds a sweep
//   that writes one text cell per cycle. No new transaction is taken until the last
//   result is loaded into the result register, and delivery waits on out_ready.
// Reset: arst_n clears control state; the text store reads as zeros through
//   per-cell valid bits, so no clearing pass runs after reset.
module char_lcd_4bit_bus_emulator_top #(
	parameter int TEXT_ROWS = 4,
	parameter int TEXT_COLS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input transactions
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lcdemu_pkg::in_item_t in_data,
	// result transactions
	output logic                 out_valid,
	input  logic                 out_ready,
	output lcdemu_pkg::result_t  out_data,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lcdemu_pkg::*;

	logic [2:0] display_rows_q;
	logic [5:0] max_columns_q;
	logic       cfg_wr;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Zero wait states: every access completes in its access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Register select by word address; the low byte-address bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_rows_q <= ROWS_RESET;
			max_columns_q  <= MAXCOL_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DISPLAY_ROWS: display_rows_q <= pwdata[2:0];
				REG_MAX_COLUMNS:  max_columns_q  <= pwdata[5:0];
				default:          display_rows_q <= display_rows_q;
			endcase
		end
	end

	// Read back: zero-extend the selected register
	always_comb begin
		case (paddr[2])
			REG_DISPLAY_ROWS: prdata = {29'd0, display_rows_q};
			REG_MAX_COLUMNS:  prdata = {26'd0, max_columns_q};
			default:          prdata = '0;
		endcase
	end

	// Sequence each transaction: accept, execute (then sweep on clear), deliver
	lcdemu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold decode state, text store and the result register
	lcdemu_datapath #(
		.TEXT_ROWS (TEXT_ROWS),
		.TEXT_COLS (TEXT_COLS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_data      (in_data),
		.out_data     (out_data),
		.display_rows (display_rows_q),
		.max_columns  (max_columns_q)
	);

endmodule

[bench/lcd_bus_checker.sv]
`timescale 1ns / 100ps
// Checker for the character LCD bus emulator: follows input, result and configuration traffic,
// predicts every result and compares it field by field. Depends on lcdemu_pkg only.
module lcd_bus_checker #(
	parameter int TEXT_ROWS = 4,
	parameter int TEXT_COLS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  lcdemu_pkg::in_item_t in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  lcdemu_pkg::result_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output int unsigned          mismatches,
	output int unsigned          pending
);
	import lcdemu_pkg::*;

	localparam int CELLS      = TEXT_ROWS * TEXT_COLS;

	// predicted configuration and controller state
	logic [2:0] rows_cfg;
	logic [5:0] maxcol_cfg;
	logic       sel_data;
	logic [8:0] nib_acc;
	logic [6:0] ddram_addr;
	logic       disp_on;
	logic [5:0] vis_cols;
	logic [7:0] cells [CELLS];

	result_t     lcd_status_q [$];
	int unsigned fail_cnt;

	task automatic write_cell(input logic [7:0] ch);
		int x;
		int y;
		int n;
		if (ddram_addr >= ADDR_WRAP)
			ddram_addr = '0;
		if (ddram_addr >= LINE1_END && ddram_addr < LINE2_START)
			ddram_addr = LINE2_START;
		x = int'(ddram_addr[5:0]);
		y = int'(ddram_addr[6]);
		// four-row panels fold the right half of each line onto the lower rows
		if (rows_cfg == FOLD_ROWS && x >= int'(FOLD_COL)) begin
			x -= int'(FOLD_COL);
			y += 2;
		end
		if (x < TEXT_COLS && y < TEXT_ROWS)
			cells[y * TEXT_COLS + x] = ch;
		ddram_addr = ddram_addr + 7'd1;
		if (x >= int'(vis_cols)) begin
			n = x + 1;
			if (n > int'(maxcol_cfg))
				n = int'(maxcol_cfg);
			vis_cols = 6'(n);
		end
	endtask

	task automatic run_command(input logic [7:0] cmd);
		if (cmd[7]) begin
			ddram_addr = cmd[6:0];
		end else if (cmd == CMD_HOME || cmd == CMD_HOME_ALT) begin
			ddram_addr = '0;
		end else if (cmd == CMD_CLEAR) begin
			foreach (cells[i])
				cells[i] = CHAR_SPACE;
			ddram_addr = '0;
		end
	endtask

	task automatic predict_lcd_status(input in_item_t txn, output result_t res);
		logic [7:0] b;
		int row;
		int col;
		b = txn.bus_byte;
		res = '0;
		if (txn.opcode == OP_READ) begin
			row = int'(txn.read_row);
			col = int'(txn.read_col);
			if (row < TEXT_ROWS && col < TEXT_COLS)
				res.read_char = cells[row * TEXT_COLS + col];
		end else if (b[BUS_EN] && !b[BUS_RW]) begin
			disp_on = b[BUS_BL];
			// a select change drops a half-built byte
			if (sel_data != b[BUS_RS]) begin
				sel_data = b[BUS_RS];
				nib_acc = ACC_EMPTY;
			end
			nib_acc = {nib_acc[4:0], b[7:4]};
			if (nib_acc[8]) begin
				if (sel_data)
					write_cell(nib_acc[7:0]);
				else
					run_command(nib_acc[7:0]);
				nib_acc = ACC_EMPTY;
			end
		end
		res.backlight_on   = disp_on;
		res.column_count   = vis_cols;
		res.cursor_address = ddram_addr;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			rows_cfg   = ROWS_RESET;
			maxcol_cfg = MAXCOL_RESET;
			sel_data   = 1'b0;
			nib_acc    = ACC_EMPTY;
			ddram_addr = '0;
			disp_on    = 1'b0;
			vis_cols   = VIS_RESET;
			foreach (cells[i])
				cells[i] = '0;
			lcd_status_q.delete();
			fail_cnt = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_DISPLAY_ROWS, 2'b00})
					rows_cfg = pwdata[2:0];
				else if (paddr == {REG_MAX_COLUMNS, 2'b00})
					maxcol_cfg = pwdata[5:0];
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (lcd_status_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: expected no result, got read_char %02h backlight_on %0b column_count %0d cursor_address %02h",
						$time, got.read_char, got.backlight_on, got.column_count,
						got.cursor_address);
				end else begin
					want = lcd_status_q.pop_front();
					if (got.read_char !== want.read_char || got.backlight_on !== want.backlight_on ||
						got.column_count !== want.column_count ||
						got.cursor_address !== want.cursor_address) begin
						fail_cnt++;
						$display("%0t: expected read_char %02h backlight_on %0b column_count %0d cursor_address %02h, got %02h %0b %0d %02h",
							$time, want.read_char, want.backlight_on, want.column_count,
							want.cursor_address, got.read_char, got.backlight_on,
							got.column_count, got.cursor_address);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_lcd_status(in_data, want);
				lcd_status_q.push_back(want);
			end
			mismatches <= fail_cnt;
			pending    <= lcd_status_q.size();
		end
	end

endmodule

[bench/tb_char_lcd_4bit_bus_emulator_top.sv]
`timescale 1ns / 100ps
// Testbench top for the character LCD bus emulator: clock, reset, configuration phases,
// input stimulus, result flow control and the verdict. Depends on lcdemu_pkg, the block
// and lcd_bus_checker.
module tb_char_lcd_4bit_bus_emulator_top;
	import lcdemu_pkg::*;

	localparam int TEXT_ROWS      = 4;
	localparam int TEXT_COLS      = 40;
	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int PHASE_ITEMS    = 240;
	localparam int LONG_HOLD      = 400;
	// a clear walks every cell once, plus the controller sequence and some margin
	localparam int DRAIN_CYCLES   = TEXT_ROWS * TEXT_COLS + 40;
	// longest correct quiet stretch is the long receiver hold; allow it many times over
	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	result_t     out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned mismatches;
	int unsigned pending;

	// flow-control knobs, in percent of cycles spent idle
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic        hold_req;
	logic        hold_done;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	char_lcd_4bit_bus_emulator_top #(
		.TEXT_ROWS(TEXT_ROWS),
		.TEXT_COLS(TEXT_COLS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lcd_bus_checker #(
		.TEXT_ROWS(TEXT_ROWS),
		.TEXT_COLS(TEXT_COLS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Result side: stall at the phase's rate, or hold off for a long stretch once on
	// request so the block backs up and drops in_ready while the sender keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles in which no transaction moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one input transaction, idling first at the sender's rate, and return at the
	// edge that accepts it. Valid stays high across back-to-back transactions.
	task automatic send_item(input in_item_t txn);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= txn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Expander byte; the read cell fields carry junk the block must ignore.
	task automatic send_bus(input logic [7:0] b);
		in_item_t txn;
		txn.opcode   = OP_BUS;
		txn.bus_byte = b;
		txn.read_row = 2'($urandom);
		txn.read_col = 6'($urandom);
		send_item(txn);
	endtask

	task automatic send_read(input logic [1:0] row, input logic [5:0] col);
		in_item_t txn;
		txn.opcode   = OP_READ;
		txn.bus_byte = 8'($urandom);
		txn.read_row = row;
		txn.read_col = col;
		send_item(txn);
	endtask

	// Strobed nibble with a random backlight bit.
	function automatic logic [7:0] bus_nibble(input logic [3:0] nib, input logic rs);
		logic [7:0] b;
		b = {nib, 4'b0000};
		b[BUS_BL] = 1'($urandom);
		b[BUS_EN] = 1'b1;
		b[BUS_RW] = 1'b0;
		b[BUS_RS] = rs;
		return b;
	endfunction

	// Whole command or data byte, high nibble first.
	task automatic send_pair(input logic rs, input logic [7:0] val);
		send_bus(bus_nibble(val[7:4], rs));
		send_bus(bus_nibble(val[3:0], rs));
	endtask

	// Drop valid and wait until the checker holds no expectation.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Program both registers back to back, then release the bus.
	task automatic configure(input logic [2:0] rows, input logic [5:0] maxcol);
		apb_write(REG_DISPLAY_ROWS, 32'(rows));
		apb_write(REG_MAX_COLUMNS, 32'(maxcol));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly whole bytes with random content; the rest reads, lone nibbles that break
	// pairing, and bytes the block ignores.
	task automatic run_random(input int unsigned n_items);
		int unsigned counted;
		int unsigned pick;
		int unsigned sel;
		logic [7:0]  cmd;
		logic [7:0]  junk;
		logic [5:0]  col;
		counted = 0;
		while (counted < n_items) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_pair(1'b1, 8'($urandom));
				counted += 2;
			end else if (pick < 65) begin
				sel = $urandom_range(99);
				if (sel < 55)
					cmd = {1'b1, 7'($urandom)};
				else if (sel < 70)
					cmd = $urandom_range(1) ? CMD_HOME : CMD_HOME_ALT;
				else if (sel < 74)
					cmd = CMD_CLEAR;
				else if (sel < 80)
					cmd = '0;
				else
					cmd = 8'($urandom_range(8'h7f, CMD_HOME_ALT + 1));
				send_pair(1'b0, cmd);
				counted += 2;
			end else if (pick < 80) begin
				// mostly inside the store, sometimes past its last column
				col = ($urandom_range(4) == 0) ? 6'($urandom_range(63, TEXT_COLS))
					: 6'($urandom_range(TEXT_COLS - 1));
				send_read(2'($urandom), col);
				counted++;
			end else if (pick < 88) begin
				send_bus(bus_nibble(4'($urandom), 1'($urandom)));
				counted++;
			end else begin
				junk = 8'($urandom);
				if (junk[BUS_EN] && !junk[BUS_RW])
					junk[BUS_RW] = 1'b1;
				send_bus(junk);
				counted++;
			end
		end
	endtask

	initial begin
		logic [7:0] b;
		in_valid      <= 1'b0;
		in_data       <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		hold_req      <= 1'b0;
		arst_n        <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset configuration, no idling.
		send_read(2'd0, 6'd0);                  // untouched store reads zero
		b = bus_nibble(4'hf, 1'b1);
		b[BUS_EN] = 1'b0;
		send_bus(b);                            // no strobe: ignored
		b[BUS_EN] = 1'b1;
		b[BUS_RW] = 1'b1;
		send_bus(b);                            // read cycle: ignored
		send_pair(1'b0, CMD_CLEAR);             // fill with spaces
		send_pair(1'b1, 8'h41);
		send_read(2'd0, 6'd0);
		send_read(2'd3, 6'd63);                 // column past the store
		send_pair(1'b0, {1'b1, 7'h27});         // end of line one, folds to row two
		send_pair(1'b1, 8'hff);
		send_pair(1'b0, {1'b1, 7'h30});         // gap between lines wraps to line two
		send_pair(1'b1, 8'h00);
		send_pair(1'b0, 8'hff);                 // top address wraps to zero
		send_pair(1'b1, 8'h7e);
		send_pair(1'b0, CMD_HOME);
		send_bus(bus_nibble(4'h8, 1'b0));       // half a command, then select flips
		send_pair(1'b1, 8'h5a);
		wait_drained();

		// Random phases: each changes the panel shape and the flow-control mix.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(3'd4, 6'd40);
				1: configure(3'd2, 6'd24);
				2: configure(3'd1, 6'd16);  // may shrink a wider column count
				3: configure(3'd3, 6'd32);
				4: configure(3'd4, 6'd20);
				5: configure(3'd1, 6'd40);
				6: configure(3'd4, 6'd16);
				default: configure(3'd2, 6'd40);
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 77;
				end
				default: begin
					send_idle_pct = 13;
					recv_idle_pct = 13;
				end
			endcase
			if (ph == 3) begin
				run_random(PHASE_ITEMS / 2);
				hold_req <= 1'b1;       // back the block up against a stalled receiver
				run_random(PHASE_ITEMS / 2);
			end else begin
				run_random(PHASE_ITEMS);
			end
			wait_drained();
		end

		// Let any trailing activity settle before the verdict.
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
